/* hw/rtl/serpentine_led_panel_mapper_macros.svh */
// Assertion macros used by the serpentine panel mapper top level.
`ifndef SERPENTINE_LED_PANEL_MAPPER_MACROS_SVH
`define SERPENTINE_LED_PANEL_MAPPER_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define SLPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define SLPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/slpm_pkg.sv */
// Types, sizes and register codes of the serpentine panel mapper.
package slpm_pkg;

  localparam int MAX_PANEL_DIM = 64;
  localparam int MAX_PANELS    = 8;
  localparam int INDEX_BITS    = 16;

  localparam int IDX_W   = INDEX_BITS;
  localparam int CNT_W   = $clog2(MAX_PANEL_DIM);
  localparam int PS_W    = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;
  localparam int PW_W    = 7;
  localparam int PC_W    = 4;
  localparam int PH_W    = 7;
  localparam int STR_W   = 10;
  localparam int BASE_W  = 16;
  localparam int PIX_W   = 16;
  localparam int LIGHT_W = 15;
  localparam int CFG_DW  = 16;
  localparam int CFG_AW  = 3;

  localparam logic [PW_W-1:0]   RST_COLS_PER_PANEL = PW_W'(8);
  localparam logic [PC_W-1:0]   RST_NUM_PANELS     = PC_W'(1);
  localparam logic [PH_W-1:0]   RST_ROWS_PER_PANEL = PH_W'(8);
  localparam logic [STR_W-1:0]  RST_ROW_STRIDE     = STR_W'(8);
  localparam logic              RST_RIGHT_TO_LEFT  = 1'b0;
  localparam logic              RST_START_UPWARD   = 1'b0;
  localparam logic [BASE_W-1:0] RST_BASE_OFFSET    = '0;

  typedef enum logic [CFG_AW-1:0] {
    REG_COLS_PER_PANEL = 3'd0,
    REG_NUM_PANELS     = 3'd1,
    REG_ROWS_PER_PANEL = 3'd2,
    REG_ROW_STRIDE     = 3'd3,
    REG_RIGHT_TO_LEFT  = 3'd4,
    REG_START_UPWARD   = 3'd5,
    REG_BASE_OFFSET    = 3'd6
  } slpm_reg_t;

  typedef struct packed {
    logic [PW_W-1:0]   cols_per_panel;
    logic [PC_W-1:0]   num_panels;
    logic [PH_W-1:0]   rows_per_panel;
    logic [STR_W-1:0]  row_stride;
    logic              right_to_left;
    logic              start_upward;
    logic [BASE_W-1:0] base_offset;
  } slpm_cfg_t;

  // Coordinates of one light, handed from the walker to the index adder.
  typedef struct packed {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   pan_col;
    logic [LIGHT_W-1:0] light;
    logic               last;
  } slpm_coord_t;

endpackage

/* hw/rtl/serpentine_led_panel_mapper.sv */
// Top level of the serpentine LED panel mapper: registers, handshake, index sum.
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_restart
//   out      output     out_valid/out_stall out_pixel_index, out_light_number, out_last_light
//   cfg      input      cfg_we              cfg_addr, cfg_wdata
// One request per clock while in_stall is low; each passes the walker register, then the output register.
// Per-light work is the walker's counter update plus one multiply-add per stage.
// Synchronous active-low reset restores register defaults and the sequence start.
// A stalled output holds; one further request is still taken into the walker stage.
`include "serpentine_led_panel_mapper_macros.svh"

module serpentine_led_panel_mapper import slpm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   out_pixel_index,
  output logic [LIGHT_W-1:0] out_light_number,
  output logic               out_last_light,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata
);

  slpm_cfg_t          cfg_r, cfg_nxt;
  slpm_coord_t        coord;
  logic               s1_valid_r, s1_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   pix_r;
  logic [LIGHT_W-1:0] light_r;
  logic               last_r;
  logic               out_adv, accept;
  logic [IDX_W-1:0]   idx;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_COLS_PER_PANEL: cfg_nxt.cols_per_panel = cfg_wdata[PW_W-1:0];
        REG_NUM_PANELS:     cfg_nxt.num_panels     = cfg_wdata[PC_W-1:0];
        REG_ROWS_PER_PANEL: cfg_nxt.rows_per_panel = cfg_wdata[PH_W-1:0];
        REG_ROW_STRIDE:     cfg_nxt.row_stride     = cfg_wdata[STR_W-1:0];
        REG_RIGHT_TO_LEFT:  cfg_nxt.right_to_left  = cfg_wdata[0];
        REG_START_UPWARD:   cfg_nxt.start_upward   = cfg_wdata[0];
        REG_BASE_OFFSET:    cfg_nxt.base_offset    = cfg_wdata[BASE_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cols_per_panel <= RST_COLS_PER_PANEL;
      cfg_r.num_panels     <= RST_NUM_PANELS;
      cfg_r.rows_per_panel <= RST_ROWS_PER_PANEL;
      cfg_r.row_stride     <= RST_ROW_STRIDE;
      cfg_r.right_to_left  <= RST_RIGHT_TO_LEFT;
      cfg_r.start_upward   <= RST_START_UPWARD;
      cfg_r.base_offset    <= RST_BASE_OFFSET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign accept   = in_valid && !in_stall;

  slpm_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .restart (in_restart),
    .coord   (coord)
  );

  always_comb begin
    s1_valid_nxt  = accept ? 1'b1 : (out_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
    idx = IDX_W'(cfg_r.base_offset) + IDX_W'(coord.row * IDX_W'(cfg_r.row_stride))
          + coord.pan_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      pix_r   <= PIX_W'(idx);
      light_r <= coord.light;
      last_r  <= coord.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_index  = pix_r;
  assign out_light_number = light_r;
  assign out_last_light   = last_r;

  `SLPM_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_r, "request lost")
  `SLPM_ASSERT_NOW(a_full_stalls, s1_valid_r && out_valid_r && out_stall, in_stall, "no stall")
  `SLPM_ASSERT_NEXT(a_restart_first, accept && in_restart, coord.light == '0, "restart not first")

endmodule

/* hw/rtl/slpm_walker.sv */
// Serpentine traversal state and first-stage coordinate register.
module slpm_walker import slpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  slpm_cfg_t   cfg,
  input  logic        accept,
  input  logic        restart,
  output slpm_coord_t coord
);

  logic [CNT_W-1:0]   cc_r, cc_nxt, cc;
  logic [CNT_W-1:0]   rc_r, rc_nxt, rc;
  logic [PS_W-1:0]    ps_r, ps_nxt, ps;
  logic [LIGHT_W-1:0] lc_r, lc_nxt, lc;
  logic               gl_r, gl_nxt, gl;
  logic               gu_r, gu_nxt, gu;
  slpm_coord_t        coord_r, coord_nxt;

  logic [PW_W-1:0]  w;
  logic [PH_W-1:0]  h;
  logic [PC_W-1:0]  pc;
  logic [IDX_W-1:0] col, row, pan;
  logic             end_col, end_row, end_pan;

  always_comb begin
    if (cfg.cols_per_panel == '0) w = PW_W'(1);
    else if (int'(cfg.cols_per_panel) > MAX_PANEL_DIM) w = PW_W'(MAX_PANEL_DIM);
    else w = cfg.cols_per_panel;

    if (cfg.rows_per_panel == '0) h = PH_W'(1);
    else if (int'(cfg.rows_per_panel) > MAX_PANEL_DIM) h = PH_W'(MAX_PANEL_DIM);
    else h = cfg.rows_per_panel;

    if (cfg.num_panels == '0) pc = PC_W'(1);
    else if (int'(cfg.num_panels) > MAX_PANELS) pc = PC_W'(MAX_PANELS);
    else pc = cfg.num_panels;
  end

  always_comb begin
    cc = restart ? '0 : cc_r;
    rc = restart ? '0 : rc_r;
    ps = restart ? '0 : ps_r;
    lc = restart ? '0 : lc_r;
    gl = restart ? cfg.right_to_left : gl_r;
    gu = restart ? cfg.start_upward : gu_r;

    // mirrored coordinates wrap modulo the index width
    col = gl ? IDX_W'(w) - IDX_W'(1) - IDX_W'(cc) : IDX_W'(cc);
    row = gu ? IDX_W'(h) - IDX_W'(1) - IDX_W'(rc) : IDX_W'(rc);
    pan = cfg.right_to_left ? IDX_W'(pc) - IDX_W'(1) - IDX_W'(ps) : IDX_W'(ps);

    end_col = (IDX_W'(cc) + IDX_W'(1)) >= IDX_W'(w);
    end_row = (IDX_W'(rc) + IDX_W'(1)) >= IDX_W'(h);
    end_pan = (IDX_W'(ps) + IDX_W'(1)) >= IDX_W'(pc);

    coord_nxt.row     = row;
    coord_nxt.pan_col = IDX_W'(pan * IDX_W'(w)) + col;
    coord_nxt.light   = lc;
    coord_nxt.last    = end_col && end_row && end_pan;

    lc_nxt = lc + LIGHT_W'(1);
    cc_nxt = cc;
    rc_nxt = rc;
    ps_nxt = ps;
    gl_nxt = gl;
    gu_nxt = gu;
    if (!end_col) begin
      cc_nxt = cc + CNT_W'(1);
    end else begin
      cc_nxt = '0;
      gl_nxt = !gl;
      if (!end_row) begin
        rc_nxt = rc + CNT_W'(1);
      end else begin
        rc_nxt = '0;
        gu_nxt = !gu;
        gl_nxt = cfg.right_to_left;
        if (!end_pan) begin
          ps_nxt = ps + PS_W'(1);
        end else begin
          ps_nxt = '0;
          lc_nxt = '0;
          gl_nxt = cfg.right_to_left;
          gu_nxt = cfg.start_upward;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
      rc_r <= '0;
      ps_r <= '0;
      lc_r <= '0;
      gl_r <= RST_RIGHT_TO_LEFT;
      gu_r <= RST_START_UPWARD;
    end else if (accept) begin
      cc_r <= cc_nxt;
      rc_r <= rc_nxt;
      ps_r <= ps_nxt;
      lc_r <= lc_nxt;
      gl_r <= gl_nxt;
      gu_r <= gu_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

/* bench/serpentine_led_panel_mapper_tb.sv */
// Self-checking bench for the serpentine LED panel mapper: predicts each light and compares it.
`timescale 1ns / 100ps

module serpentine_led_panel_mapper_tb import slpm_pkg::*; ();

  localparam int STALL_LIMIT  = 2000;
  localparam int TOTAL_ITEMS  = 1100;
  localparam int CALM_TAIL    = 150;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [LIGHT_W-1:0] number;
    logic               last;
  } light_t;

  class light_scoreboard;
    logic [PW_W-1:0]    cols_per_panel = RST_COLS_PER_PANEL;
    logic [PC_W-1:0]    num_panels     = RST_NUM_PANELS;
    logic [PH_W-1:0]    rows_per_panel = RST_ROWS_PER_PANEL;
    logic [STR_W-1:0]   row_stride     = RST_ROW_STRIDE;
    logic               right_to_left  = RST_RIGHT_TO_LEFT;
    logic               start_upward   = RST_START_UPWARD;
    logic [BASE_W-1:0]  base_offset    = RST_BASE_OFFSET;

    logic [CNT_W-1:0]   col_step  = '0;
    logic [CNT_W-1:0]   row_step  = '0;
    logic [PS_W-1:0]    pan_step  = '0;
    logic [LIGHT_W-1:0] light_cnt = '0;
    logic               go_left   = RST_RIGHT_TO_LEFT;
    logic               go_up     = RST_START_UPWARD;

    light_t pending_lights[$];
    int     errors = 0;

    function void restart_walk();
      col_step  = '0;
      row_step  = '0;
      pan_step  = '0;
      light_cnt = '0;
      go_left   = right_to_left;
      go_up     = start_upward;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(slpm_reg_t r, logic [CFG_DW-1:0] v);
      case (r)
        REG_COLS_PER_PANEL: cols_per_panel = v[PW_W-1:0];
        REG_NUM_PANELS:     num_panels     = v[PC_W-1:0];
        REG_ROWS_PER_PANEL: rows_per_panel = v[PH_W-1:0];
        REG_ROW_STRIDE:     row_stride     = v[STR_W-1:0];
        REG_RIGHT_TO_LEFT:  right_to_left  = v[0];
        REG_START_UPWARD:   start_upward   = v[0];
        REG_BASE_OFFSET:    base_offset    = v[BASE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic restart);
      int unsigned w, h, pc;
      logic [IDX_W-1:0] col, row, pan, idx;
      bit end_col, end_row, end_pan;
      light_t exp;
      w  = clamp_dim(cols_per_panel, MAX_PANEL_DIM);
      h  = clamp_dim(rows_per_panel, MAX_PANEL_DIM);
      pc = clamp_dim(num_panels, MAX_PANELS);
      if (restart) restart_walk();
      // mirrored coordinates wrap when a counter sits past a shrunken bound
      col = go_left ? IDX_W'(w - 1 - col_step) : IDX_W'(col_step);
      row = go_up ? IDX_W'(h - 1 - row_step) : IDX_W'(row_step);
      pan = right_to_left ? IDX_W'(pc - 1 - pan_step) : IDX_W'(pan_step);
      idx = IDX_W'(base_offset + row * row_stride + pan * w + col);
      end_col = (col_step + 1 >= w);
      end_row = (row_step + 1 >= h);
      end_pan = (pan_step + 1 >= pc);
      exp.pixel  = idx[PIX_W-1:0];
      exp.number = light_cnt;
      exp.last   = end_col && end_row && end_pan;
      pending_lights.push_back(exp);

      light_cnt = light_cnt + 1'b1;
      if (!end_col) begin
        col_step = col_step + 1'b1;
      end else begin
        col_step = '0;
        go_left  = !go_left;
        if (!end_row) begin
          row_step = row_step + 1'b1;
        end else begin
          row_step = '0;
          go_up    = !go_up;
          go_left  = right_to_left;
          if (!end_pan) pan_step = pan_step + 1'b1;
          else restart_walk();
        end
      end
    endfunction

    function void check_light(logic [PIX_W-1:0] pixel, logic [LIGHT_W-1:0] number, logic last);
      light_t exp;
      if (pending_lights.size() == 0) begin
        $error("unexpected light: pixel_index %0d light_number %0d", pixel, number);
        errors++;
        return;
      end
      exp = pending_lights.pop_front();
      if (pixel !== exp.pixel) begin
        $error("pixel_index: expected %0d, actual %0d", exp.pixel, pixel);
        errors++;
      end
      if (number !== exp.number) begin
        $error("light_number: expected %0d, actual %0d", exp.number, number);
        errors++;
      end
      if (last !== exp.last) begin
        $error("last_light: expected %0d, actual %0d", exp.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [PIX_W-1:0]   out_pixel_index;
  logic [LIGHT_W-1:0] out_light_number;
  logic               out_last_light;
  logic               cfg_we     = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr   = '0;
  logic [CFG_DW-1:0]  cfg_wdata  = '0;

  light_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent  = 0;
  int quiet_cycles = 0;

  serpentine_led_panel_mapper dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_index  (out_pixel_index),
    .out_light_number (out_light_number),
    .out_last_light   (out_last_light),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : rx_stall
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (burst > 0 && rx_idle_pct > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        burst = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_light(out_pixel_index, out_light_number, out_last_light);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int reg_width(slpm_reg_t r);
    case (r)
      REG_COLS_PER_PANEL: return PW_W;
      REG_NUM_PANELS:     return PC_W;
      REG_ROWS_PER_PANEL: return PH_W;
      REG_ROW_STRIDE:     return STR_W;
      REG_BASE_OFFSET:    return BASE_W;
      default:            return 1;
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return MAX_PANEL_DIM;
      2:       return $urandom_range(MAX_PANEL_DIM + 1, 127);
      3:       return $urandom_range(1, MAX_PANEL_DIM);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return MAX_PANELS;
      2:       return $urandom_range(MAX_PANELS + 1, 15);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // unused upper data bits carry random junk; leaves cfg_we high for a following write
  task automatic write_reg(slpm_reg_t r, int val);
    logic [CFG_DW-1:0] d, mask;
    mask = CFG_DW'((1 << reg_width(r)) - 1);
    d = CFG_DW'($urandom());
    d = (d & ~mask) | (CFG_DW'(val) & mask);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= d;
    @(posedge clk);
    sb.set_reg(r, d);
    @(negedge clk);
  endtask

  task automatic send_light(logic restart);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(restart);
    items_sent++;
    @(negedge clk);
  endtask

  // hold requests until the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_lights.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic randomize_settings();
    if ($urandom_range(0, 1)) write_reg(REG_COLS_PER_PANEL, pick_dim());
    if ($urandom_range(0, 1)) write_reg(REG_NUM_PANELS, pick_count());
    if ($urandom_range(0, 1)) write_reg(REG_ROWS_PER_PANEL, pick_dim());
    if ($urandom_range(0, 4) < 3)
      write_reg(REG_ROW_STRIDE, sb.clamp_dim(sb.cols_per_panel, MAX_PANEL_DIM) *
                                sb.clamp_dim(sb.num_panels, MAX_PANELS));
    else if ($urandom_range(0, 1))
      write_reg(REG_ROW_STRIDE, $urandom_range(0, 1023));
    if ($urandom_range(0, 1)) write_reg(REG_RIGHT_TO_LEFT, $urandom_range(0, 1));
    if ($urandom_range(0, 1)) write_reg(REG_START_UPWARD, $urandom_range(0, 1));
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0:       write_reg(REG_BASE_OFFSET, 16'hFFFF);
        1:       write_reg(REG_BASE_OFFSET, 0);
        default: write_reg(REG_BASE_OFFSET, $urandom_range(0, 16'hFFFF));
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    int restart_pct;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 15;
    rx_idle_pct = 15;

    // sequence state straight out of reset, then a restart
    send_light(1'b0);
    send_light(1'b0);
    send_light(1'b1);

    // single-light array: every light is the last one
    settle();
    write_reg(REG_COLS_PER_PANEL, 1);
    write_reg(REG_NUM_PANELS, 1);
    write_reg(REG_ROWS_PER_PANEL, 1);
    write_reg(REG_BASE_OFFSET, 16'hFFFF);
    write_reg(REG_ROW_STRIDE, 1023);
    cfg_we <= 1'b0;
    repeat (3) send_light(1'b0);

    // out-of-range sizes, zero stride, index overflow, reversed directions
    settle();
    write_reg(REG_COLS_PER_PANEL, 0);
    write_reg(REG_ROWS_PER_PANEL, 127);
    write_reg(REG_NUM_PANELS, 15);
    write_reg(REG_RIGHT_TO_LEFT, 1);
    write_reg(REG_START_UPWARD, 1);
    write_reg(REG_ROW_STRIDE, 0);
    cfg_we <= 1'b0;
    send_light(1'b0);
    send_light(1'b1);
    send_light(1'b0);

    settle();
    write_reg(REG_COLS_PER_PANEL, 100);
    write_reg(REG_NUM_PANELS, 0);
    write_reg(REG_ROWS_PER_PANEL, 0);
    write_reg(REG_ROW_STRIDE, 1023);
    cfg_we <= 1'b0;
    repeat (3) send_light(1'b0);

    // shrink the array mid-sequence with counters past the new bounds
    settle();
    write_reg(REG_COLS_PER_PANEL, 8);
    write_reg(REG_NUM_PANELS, 3);
    write_reg(REG_ROWS_PER_PANEL, 5);
    write_reg(REG_RIGHT_TO_LEFT, 1);
    write_reg(REG_START_UPWARD, 1);
    write_reg(REG_ROW_STRIDE, 24);
    write_reg(REG_BASE_OFFSET, 0);
    cfg_we <= 1'b0;
    send_light(1'b1);
    repeat (4) send_light(1'b0);
    settle();
    write_reg(REG_COLS_PER_PANEL, 2);
    write_reg(REG_ROWS_PER_PANEL, 1);
    write_reg(REG_NUM_PANELS, 1);
    cfg_we <= 1'b0;
    repeat (4) send_light(1'b0);

    while (items_sent < TOTAL_ITEMS) begin
      settle();
      randomize_settings();
      if (items_sent >= TOTAL_ITEMS - CALM_TAIL) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      case ($urandom_range(0, 11))
        0:       restart_pct = 100;
        1, 2:    restart_pct = 0;
        3, 4:    restart_pct = 15;
        default: restart_pct = 2;
      endcase
      n = $urandom_range(10, 70);
      repeat (n) send_light($urandom_range(0, 99) < restart_pct);
    end

    in_valid <= 1'b0;
    while (sb.pending_lights.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (sb.errors == 0 && sb.pending_lights.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
